@@ hdl/psl_pkg.sv @@
// Shared types, widths and constants for the polynomial slew limiter.
// No dependencies; every other file in hdl/ depends on this package.
package psl_pkg;

    localparam int SAMPLE_WIDTH    = 24;
    localparam int FRAC_BITS       = 21;
    localparam int LIMIT_WIDTH     = SAMPLE_WIDTH - 1;
    localparam int CUBE_WIDTH      = SAMPLE_WIDTH - 2;
    // Headroom for 3x history terms plus 6x cube bound without overflow.
    localparam int WIDE_WIDTH      = SAMPLE_WIDTH + 5;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = LIMIT_WIDTH;
    localparam int HIST_DEPTH      = 3;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [WIDE_WIDTH-1:0]   t_wide;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_INVERT  = 2'd1,
        MODE_REVERSE = 2'd2,
        MODE_DRY     = 2'd3
    } t_mode;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MODE      = 3'd0,
        CFG_AMP_LIMIT = 3'd1,
        CFG_SLEW_STEP = 3'd2,
        CFG_QUAD      = 3'd3,
        CFG_CUBE      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        t_mode                  mode;
        logic [LIMIT_WIDTH-1:0] amp_limit;
        logic [LIMIT_WIDTH-1:0] slew_step;
        logic [LIMIT_WIDTH-1:0] quad_bound;
        logic [CUBE_WIDTH-1:0]  cube_bound;
    } t_cfg;

    localparam logic [LIMIT_WIDTH-1:0] RESET_LIMIT = LIMIT_WIDTH'(1) << (LIMIT_WIDTH - 1);
    localparam logic [CUBE_WIDTH-1:0]  RESET_CUBE  = CUBE_WIDTH'(2796203);

    localparam t_wide WIDE_ONE    = t_wide'(1) <<< FRAC_BITS;
    localparam t_wide WIDE_SAT_HI = t_wide'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    localparam t_wide WIDE_SAT_LO = -WIDE_SAT_HI - t_wide'(1);

endpackage

@@ hdl/psl_channel.sv @@
// One channel of the limiter: difference clamps, slew and amplitude clamps.
// Purely combinational; depends on psl_pkg.
module psl_channel (
    input  psl_pkg::t_cfg    i_cfg,
    input  psl_pkg::t_sample i_hist0,
    input  psl_pkg::t_sample i_hist1,
    input  psl_pkg::t_sample i_hist2,
    input  psl_pkg::t_sample i_sample,
    output psl_pkg::t_sample o_result
);
    import psl_pkg::*;

    t_wide x_w, h0_w, h1_w, h2_w;
    t_wide d3, d2, base3, base2;
    t_wide c_w, c6, q2, sl, lim;
    t_wide y;

    assign x_w  = t_wide'(i_sample);
    assign h0_w = t_wide'(i_hist0);
    assign h1_w = t_wide'(i_hist1);
    assign h2_w = t_wide'(i_hist2);

    // Differences always come from the raw input.
    assign base3 = h0_w - ((h1_w <<< 1) + h1_w) + ((h2_w <<< 1) + h2_w);
    assign base2 = (h2_w <<< 1) - h1_w;
    assign d3    = x_w - base3;
    assign d2    = x_w - base2;

    assign c_w = t_wide'(i_cfg.cube_bound);
    assign c6  = (c_w <<< 2) + (c_w <<< 1);
    assign q2  = t_wide'(i_cfg.quad_bound) <<< 1;
    assign sl  = t_wide'(i_cfg.slew_step);
    assign lim = t_wide'(i_cfg.amp_limit);

    always_comb begin
        y = x_w;
        unique case (i_cfg.mode)
            MODE_NORMAL: begin
                if (d3 > c6) begin
                    y = base3 + c6;
                end else if (d3 < -c6) begin
                    y = base3 - c6;
                end
                if (d2 > q2) begin
                    y = base2 + q2;
                end else if (d2 < -q2) begin
                    y = base2 - q2;
                end
                if (y - h2_w > sl) begin
                    y = h2_w + sl;
                end else if (y - h2_w < -sl) begin
                    y = h2_w - sl;
                end
                if (y > lim) begin
                    y = lim;
                end else if (y < -lim) begin
                    y = -lim;
                end
            end
            MODE_INVERT: begin
                if (d3 > c6) begin
                    y = base3 - c6;
                end else if (d3 < -c6) begin
                    y = base3 + c6;
                end
                if (d2 > q2) begin
                    y = base2 - q2;
                end else if (d2 < -q2) begin
                    y = base2 + q2;
                end
                if (y - h2_w > sl) begin
                    y = h2_w - sl;
                end else if (y - h2_w < -sl) begin
                    y = h2_w + sl;
                end
                // Overrun snaps to plus or minus one (WIDE_ONE).
                if (y > lim) begin
                    y = WIDE_ONE;
                end else if (y < -lim) begin
                    y = -WIDE_ONE;
                end
            end
            MODE_REVERSE: begin
                if (y > lim) begin
                    y = lim;
                end else if (y < -lim) begin
                    y = -lim;
                end
                if (y - h2_w > sl) begin
                    y = h2_w + sl;
                end else if (y - h2_w < -sl) begin
                    y = h2_w - sl;
                end
                if (d2 > q2) begin
                    y = base2 + q2;
                end else if (d2 < -q2) begin
                    y = base2 - q2;
                end
                if (d3 > c6) begin
                    y = base3 + c6;
                end else if (d3 < -c6) begin
                    y = base3 - c6;
                end
            end
            MODE_DRY: begin
                y = x_w;
            end
        endcase
    end

    always_comb begin
        if (y > WIDE_SAT_HI) begin
            o_result = t_sample'(WIDE_SAT_HI);
        end else if (y < WIDE_SAT_LO) begin
            o_result = t_sample'(WIDE_SAT_LO);
        end else begin
            o_result = t_sample'(y);
        end
    end

endmodule

@@ hdl/polynomial_slew_limiter.sv @@
// Top level of the stereo polynomial slew limiter: handshakes, config registers,
// sample history. Depends on psl_pkg and psl_channel.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one stereo frame per transfer.
//   Output channel (o_out_valid / i_out_stall) carries one limited frame per
//   transfer, in input order. Config writes go over i_cfg_valid / o_cfg_ready
//   with a register index and data; o_cfg_ready is always high. Write config only
//   while the block is idle.
// Path: a frame transferred in is captured in the input register, and its result
//   is loaded into the output register when the output side does not stall.
// Throughput: one frame per cycle while the output side does not stall. The rate is
//   set by the history loop: a frame's saturated result enters the history at the
//   same edge that loads the output register, so the next frame sees it right away.
// Reset (synchronous, active low): clears history to zero, empties both registers
//   and loads config defaults (dry mode, amplitude, slew and quad limits at 2.0).
// Stall: while the output register holds an untaken result and i_out_stall is
//   high, the input register cannot advance; o_in_stall rises only if it also
//   holds a frame. An empty input register always takes a new frame.
module polynomial_slew_limiter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  psl_pkg::t_sample                      i_left_sample,
    input  psl_pkg::t_sample                      i_right_sample,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output psl_pkg::t_sample                      o_left_out,
    output psl_pkg::t_sample                      o_right_out,
    // config write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [psl_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [psl_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data
);
    import psl_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_vld;
    t_sample r_x_left, r_x_right;
    t_sample r_hist_left  [HIST_DEPTH];
    t_sample r_hist_right [HIST_DEPTH];
    logic    r_out_vld;
    t_sample r_out_left, r_out_right;

    t_sample n_out_left, n_out_right;
    logic    in_xfer, advance;

    // Advance the input register whenever the output register is free or drains.
    assign advance     = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !advance;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_vld;
    assign o_left_out  = r_out_left;
    assign o_right_out = r_out_right;

    // Config registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= MODE_DRY;
            r_cfg.amp_limit  <= RESET_LIMIT;
            r_cfg.slew_step  <= RESET_LIMIT;
            r_cfg.quad_bound <= RESET_LIMIT;
            r_cfg.cube_bound <= RESET_CUBE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:      r_cfg.mode       <= t_mode'(i_cfg_data[1:0]);
                CFG_AMP_LIMIT: r_cfg.amp_limit  <= i_cfg_data[LIMIT_WIDTH-1:0];
                CFG_SLEW_STEP: r_cfg.slew_step  <= i_cfg_data[LIMIT_WIDTH-1:0];
                CFG_QUAD:      r_cfg.quad_bound <= i_cfg_data[LIMIT_WIDTH-1:0];
                CFG_CUBE:      r_cfg.cube_bound <= i_cfg_data[CUBE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x_left  <= i_left_sample;
            r_x_right <= i_right_sample;
        end
    end

    psl_channel u_left (
        .i_cfg    (r_cfg),
        .i_hist0  (r_hist_left[0]),
        .i_hist1  (r_hist_left[1]),
        .i_hist2  (r_hist_left[2]),
        .i_sample (r_x_left),
        .o_result (n_out_left)
    );

    psl_channel u_right (
        .i_cfg    (r_cfg),
        .i_hist0  (r_hist_right[0]),
        .i_hist1  (r_hist_right[1]),
        .i_hist2  (r_hist_right[2]),
        .i_sample (r_x_right),
        .o_result (n_out_right)
    );

    // History: shift in the saturated result as it is loaded for output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist_left[i]  <= '0;
                r_hist_right[i] <= '0;
            end
        end else if (advance) begin
            for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                r_hist_left[i]  <= r_hist_left[i+1];
                r_hist_right[i] <= r_hist_right[i+1];
            end
            r_hist_left[HIST_DEPTH-1]  <= n_out_left;
            r_hist_right[HIST_DEPTH-1] <= n_out_right;
        end
    end

    // Output register: hold while stalled, drop valid after a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_left  <= n_out_left;
            r_out_right <= n_out_right;
        end
    end

endmodule

@@ hdl/psl_checker.sv @@
// Port-level checks for polynomial_slew_limiter, attached by bind.
// Depends on psl_pkg.
module psl_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input psl_pkg::t_sample                      o_left_out,
    input psl_pkg::t_sample                      o_right_out
);

    // Stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // Stalled result payload does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_left_out) && $stable(o_right_out))
        else $error("output payload changed while stalled");

    // Input backpressure only comes from a blocked output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // An accepted frame passes through the input register and reaches the output unless blocked.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !(o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("accepted frame did not reach the output");

endmodule

bind polynomial_slew_limiter psl_checker u_psl_checker (.*);
